// ===== design/asm_pkg.sv =====
// Package for the aggregation slot manager: codes, widths, state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asm_pkg;
    localparam int MAX_SLOTS_DEF   = 512;
    localparam int MAX_WORKERS_DEF = 16;
    localparam int SEQ_W   = 32;
    localparam int SLOT_W  = 9;
    localparam int WRK_W   = 4;
    localparam int PAY_W   = 16;
    localparam int ACT_W   = 3;
    localparam int CMD_W   = 2;
    localparam int WC_W    = 5;
    localparam int SC_W    = 10;
    localparam int CFG_W   = 10;

    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TIMER = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [ACT_W-1:0] ACT_ACK    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NAK    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RESULT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ARM    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CANCEL = 3'd4;

    localparam logic CFG_WORKERS = 1'b0;
    localparam logic CFG_SLOTS   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_DECIDE, ST_NAK, ST_BCAST, ST_ARM,
        ST_ACK, ST_RESEND, ST_RESEND_ARM, ST_CANCEL, ST_ONE, ST_WRITE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [SEQ_W-1:0] seq_number;
        logic [SLOT_W-1:0] slot;
        logic [WRK_W-1:0] worker;
        logic [PAY_W-1:0] payload_handle;
    } in_item_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [SEQ_W-1:0] out_seq;
        logic [SLOT_W-1:0] out_slot;
        logic [WRK_W-1:0] out_worker;
        logic [PAY_W-1:0] out_payload;
        logic last;
    } out_item_t;
endpackage
`default_nettype wire

// ===== design/asm_if.sv =====
// Valid/ready channel interface carrying one payload structure.
// Depends on no package; the payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface asm_if #(parameter type PAYLOAD_T = logic) ();
    logic     valid;
    logic     ready;
    PAYLOAD_T data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/asm_slot_mem.sv =====
// Slot state memory: one synchronous RAM, one write and one read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module asm_slot_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/aggregation_slot_manager.sv =====
// Top level of the aggregation slot manager: sequencer and slot memory.
// Depends on asm_pkg, asm_if and asm_slot_mem.
//
// Use: items (command, seq_number, slot, worker, payload_handle) arrive on the
// in_ch channel; packet and timer actions leave on out_ch, one transfer per
// action, with last set on the final action of an item. Configuration writes
// (worker_count at index 0, slot_count at index 1) must be made only while
// idle; the block itself does not enforce it. Each item is handled alone:
// the item is taken, its slot entry is read from memory, a decision is made,
// then any actions are emitted and, where the slot state changes, the entry
// is written back. The slot state sits in one RAM read and written at most
// once per item. After reset a clearing pass writes the reset state to every
// slot entry, one per cycle, during which no item is accepted.
// When the receiver stalls the sequencer holds the pending action in the
// output register and waits; no action is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module aggregation_slot_manager #(
    parameter int MAX_SLOTS   = asm_pkg::MAX_SLOTS_DEF,
    parameter int MAX_WORKERS = asm_pkg::MAX_WORKERS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [asm_pkg::CFG_W-1:0] cfg_data,
    asm_if.sink                           in_ch,
    asm_if.source                         out_ch
);
    localparam int AW  = $clog2(MAX_SLOTS);
    localparam int MW  = MAX_WORKERS;
    localparam int CW  = $clog2(MAX_WORKERS + 1);
    localparam int WIW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int SW  = asm_pkg::SEQ_W;
    localparam int PW  = asm_pkg::PAY_W;
    localparam int SC_W_L = $clog2(MAX_SLOTS + 1);
    localparam int WRK_L  = asm_pkg::WRK_W;

    typedef struct packed {
        logic [SW-1:0] exp_seq;
        logic [MW-1:0] arr_mask;
        logic [CW-1:0] arr_cnt;
        logic [PW-1:0] agg_pay;
        logic          busy;
        logic [SW-1:0] b_seq;
        logic [MW-1:0] ack_mask;
        logic [CW-1:0] ack_cnt;
        logic [PW-1:0] b_pay;
    } slot_t;
    localparam int EW = $bits(slot_t);

    asm_pkg::state_t state_reg, state_next;
    logic [asm_pkg::WC_W-1:0] wcfg_reg;
    logic [asm_pkg::SC_W-1:0] scfg_reg;
    asm_pkg::in_item_t item_reg, item_next;
    slot_t ent_reg, ent_next;
    slot_t rd_ent;
    logic [AW:0] clr_reg, clr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic pend_reg, pend_next;   // a follow-up move is still to be tried
    asm_pkg::out_item_t obuf_reg, obuf_next;
    logic ovalid_reg, ovalid_next;

    logic we;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    // Effective register values, clamped to the legal range.
    logic [CW-1:0] wc;
    logic [SC_W_L-1:0] sc;
    always_comb
    begin
        if (wcfg_reg == '0)
            wc = CW'(1);
        else if (32'(wcfg_reg) > MAX_WORKERS)
            wc = CW'(MAX_WORKERS);
        else
            wc = CW'(wcfg_reg);
        if (scfg_reg == '0)
            sc = SC_W_L'(1);
        else if (32'(scfg_reg) > MAX_SLOTS)
            sc = SC_W_L'(MAX_SLOTS);
        else
            sc = SC_W_L'(scfg_reg);
    end

    asm_slot_mem #(.DEPTH(MAX_SLOTS), .WIDTH(EW)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (item_reg.slot[AW-1:0]),
        .rdata (rdata)
    );
    assign rd_ent = slot_t'(rdata);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcfg_reg <= asm_pkg::WC_W'(8);
            scfg_reg <= asm_pkg::SC_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_index[0])
                asm_pkg::CFG_WORKERS: wcfg_reg <= cfg_data[asm_pkg::WC_W-1:0];
                asm_pkg::CFG_SLOTS:   scfg_reg <= cfg_data[asm_pkg::SC_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= asm_pkg::ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ent_reg  <= ent_next;
        obuf_reg <= obuf_next;
    end

    assign in_ch.ready  = (state_reg == asm_pkg::ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = obuf_reg;

    // Next state, slot update and action generation.
    always_comb
    begin
        logic out_free;
        logic [WIW-1:0] wi;
        logic done;
        logic [CW-1:0] nxt;
        logic found;
        state_next  = state_reg;
        clr_next    = clr_reg;
        item_next   = item_reg;
        ent_next    = ent_reg;
        obuf_next   = obuf_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        we          = 1'b0;
        waddr       = item_reg.slot[AW-1:0];
        wdata       = EW'(ent_reg);
        out_free    = !ovalid_reg || out_ch.ready;
        ovalid_next = ovalid_reg && !out_ch.ready;
        wi          = item_reg.worker[WIW-1:0];
        done        = (ent_reg.arr_cnt == wc);
        nxt         = idx_reg;
        found       = 1'b0;
        case (state_reg)
            asm_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = EW'(slot_t'{exp_seq: SW'(clr_reg), default: '0});
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_SLOTS - 1)
                    state_next = asm_pkg::ST_IDLE;
            end
            asm_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_ch.data;
                    if ({1'b0, in_ch.data.slot} >= 10'(sc)
                        || in_ch.data.command == asm_pkg::CMD_NONE
                        || (in_ch.data.command != asm_pkg::CMD_TIMER
                            && {1'b0, in_ch.data.worker} >= 5'(wc)))
                        state_next = asm_pkg::ST_IDLE;
                    else
                        state_next = asm_pkg::ST_READ;
                end
            end
            asm_pkg::ST_READ:
            begin
                state_next = asm_pkg::ST_DECIDE;
            end
            asm_pkg::ST_DECIDE:
            begin
                ent_next  = rd_ent;
                state_next = asm_pkg::ST_WRITE;
                idx_next  = '0;
                pend_next = 1'b0;
                begin
                    slot_t e;
                    e = rd_ent;
                    case (item_reg.command)
                        asm_pkg::CMD_DATA:
                        begin
                            if (item_reg.seq_number < e.exp_seq)
                            begin
                                if (e.busy && e.b_seq == item_reg.seq_number)
                                    state_next = asm_pkg::ST_ONE;
                                else
                                    state_next = asm_pkg::ST_IDLE;
                            end
                            else if (item_reg.seq_number > e.exp_seq)
                            begin
                                if (e.arr_cnt == wc)
                                begin
                                    if (!e.busy)
                                    begin
                                        pend_next  = 1'b1;
                                        state_next = asm_pkg::ST_BCAST;
                                    end
                                    else
                                        state_next = asm_pkg::ST_IDLE;
                                end
                                else
                                    state_next = asm_pkg::ST_NAK;
                            end
                            else if (e.arr_mask[item_reg.worker[WIW-1:0]])
                                state_next = asm_pkg::ST_IDLE;
                            else
                            begin
                                ent_next.arr_mask[item_reg.worker[WIW-1:0]] = 1'b1;
                                ent_next.arr_cnt = e.arr_cnt + 1'b1;
                                ent_next.agg_pay = item_reg.payload_handle;
                                state_next = asm_pkg::ST_ACK;
                            end
                        end
                        asm_pkg::CMD_ACK:
                        begin
                            if (!e.busy || e.b_seq != item_reg.seq_number)
                                state_next = asm_pkg::ST_IDLE;
                            else
                            begin
                                if (!e.ack_mask[item_reg.worker[WIW-1:0]])
                                begin
                                    ent_next.ack_mask[item_reg.worker[WIW-1:0]] = 1'b1;
                                    ent_next.ack_cnt = e.ack_cnt + 1'b1;
                                end
                                if (ent_next.ack_cnt == wc)
                                    state_next = asm_pkg::ST_CANCEL;
                                else
                                    state_next = asm_pkg::ST_WRITE;
                            end
                        end
                        default:
                        begin
                            if (e.busy)
                                state_next = asm_pkg::ST_RESEND;
                            else
                                state_next = asm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            asm_pkg::ST_ACK:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_ACK, item_reg.seq_number, item_reg.slot,
                                  item_reg.worker, '0, !(done && !ent_reg.busy)};
                    if (done && !ent_reg.busy)
                        state_next = asm_pkg::ST_BCAST;
                    else
                        state_next = asm_pkg::ST_WRITE;
                end
            end
            asm_pkg::ST_ONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_RESULT, ent_reg.b_seq, item_reg.slot,
                                  item_reg.worker, ent_reg.b_pay, 1'b1};
                    state_next = asm_pkg::ST_IDLE;
                end
            end
            asm_pkg::ST_NAK:
            begin
                // Walk the workers, one missing worker per transfer.
                for (int k = MW - 1; k >= 0; k--)
                begin
                    if (CW'(k) >= idx_reg && CW'(k) < wc && !ent_reg.arr_mask[k])
                    begin
                        nxt   = CW'(k);
                        found = 1'b1;
                    end
                end
                if (!found)
                    state_next = asm_pkg::ST_IDLE;
                else if (out_free)
                begin
                    logic more;
                    more = 1'b0;
                    for (int k = 0; k < MW; k++)
                    begin
                        if (CW'(k) > nxt && CW'(k) < wc && !ent_reg.arr_mask[k])
                            more = 1'b1;
                    end
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_NAK, ent_reg.exp_seq, item_reg.slot,
                                  WRK_L'(nxt), '0, !more};
                    idx_next = nxt + 1'b1;
                    if (!more)
                        state_next = asm_pkg::ST_IDLE;
                end
            end
            asm_pkg::ST_BCAST:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_RESULT, ent_reg.exp_seq, item_reg.slot,
                                  WRK_L'(idx_reg), ent_reg.agg_pay, 1'b0};
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == wc)
                        state_next = asm_pkg::ST_ARM;
                end
            end
            asm_pkg::ST_ARM:
            begin
                if (out_free)
                begin
                    logic cont;
                    ent_next.busy     = 1'b1;
                    ent_next.b_seq    = ent_reg.exp_seq;
                    ent_next.b_pay    = ent_reg.agg_pay;
                    ent_next.ack_mask = '0;
                    ent_next.ack_cnt  = '0;
                    ent_next.exp_seq  = ent_reg.exp_seq + SW'(sc);
                    ent_next.arr_mask = '0;
                    ent_next.arr_cnt  = '0;
                    // After a move on a newer data packet, that packet may now fit.
                    // It is counted silently, and the stage is busy, so the arm ends the item.
                    cont = pend_reg && item_reg.seq_number == ent_next.exp_seq;
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_ARM, ent_reg.exp_seq, item_reg.slot,
                                  '0, '0, 1'b1};
                    pend_next  = 1'b0;
                    idx_next   = '0;
                    if (cont)
                    begin
                        ent_next.arr_mask[wi] = 1'b1;
                        ent_next.arr_cnt      = CW'(1);
                        ent_next.agg_pay      = item_reg.payload_handle;
                    end
                    state_next = asm_pkg::ST_WRITE;
                end
            end
            asm_pkg::ST_CANCEL:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_CANCEL, ent_reg.b_seq, item_reg.slot,
                                  '0, '0, !(done)};
                    ent_next.busy     = 1'b0;
                    ent_next.b_seq    = '0;
                    ent_next.ack_mask = '0;
                    ent_next.ack_cnt  = '0;
                    idx_next = '0;
                    if (done)
                        state_next = asm_pkg::ST_BCAST;
                    else
                        state_next = asm_pkg::ST_WRITE;
                end
            end
            asm_pkg::ST_RESEND:
            begin
                for (int k = MW - 1; k >= 0; k--)
                begin
                    if (CW'(k) >= idx_reg && CW'(k) < wc && !ent_reg.ack_mask[k])
                    begin
                        nxt   = CW'(k);
                        found = 1'b1;
                    end
                end
                if (!found)
                    state_next = asm_pkg::ST_RESEND_ARM;
                else if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_RESULT, ent_reg.b_seq, item_reg.slot,
                                  WRK_L'(nxt), ent_reg.b_pay, 1'b0};
                    idx_next = nxt + 1'b1;
                end
            end
            asm_pkg::ST_RESEND_ARM:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    obuf_next = '{asm_pkg::ACT_ARM, ent_reg.b_seq, item_reg.slot,
                                  '0, '0, 1'b1};
                    state_next = asm_pkg::ST_IDLE;
                end
            end
            asm_pkg::ST_WRITE:
            begin
                we = 1'b1;
                state_next = asm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = asm_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire
